// ===== sv/dpa_pkg.sv =====
// ----------------------------------------------------------------------------
// dpa_pkg
// Shared types, widths, control-word encoding and microcode program of the
// date period adder.
// ----------------------------------------------------------------------------
package dpa_pkg;

	// Block limits.
	localparam int unsigned YEAR_LIMIT = 9999;
	localparam int unsigned DAYS_WIDTH = 16;

	// Field widths of the request and result.
	localparam int unsigned YEAR_IO_W   = 14;
	localparam int unsigned MONTH_IO_W  = 4;
	localparam int unsigned DAY_IO_W    = 5;
	localparam int unsigned ADD_YEARS_W = 14;
	localparam int unsigned ADD_MONTH_W = 10;
	localparam int unsigned ADD_DAYS_W  = 16;

	// Working widths. The year grows by both added years, the month carry and
	// the day carry, which stays below 2^18 over the whole parameter range.
	localparam int unsigned YEAR_W  = 18;
	localparam int unsigned MONTH_W = 11;
	localparam int unsigned DAY_W   = DAYS_WIDTH + 1;
	localparam int unsigned REM_W   = 5;
	localparam int unsigned PC_W    = 3;

	localparam int unsigned MONTHS_PER_YEAR = 12;
	localparam int unsigned CENTURY_FACTOR  = 25;

	// Reciprocal of 25 for the year quotient: floor(year * RECIP_CENTURY >>
	// QUOT_SHIFT) equals floor(year / 25) for every year of YEAR_W bits.
	localparam int unsigned QUOT_SHIFT    = YEAR_W + $clog2(CENTURY_FACTOR);
	localparam int unsigned RECIP_CENTURY = ((1 << QUOT_SHIFT) + CENTURY_FACTOR - 1) /
		CENTURY_FACTOR;
	localparam int unsigned RECIP_W       = $clog2(RECIP_CENTURY + 1);
	localparam int unsigned QUOT_W        = YEAR_W + RECIP_W - QUOT_SHIFT;

	// Datapath operations.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_NORM,
		OP_MOD_MUL,
		OP_MOD_SUB,
		OP_DAY,
		OP_EMIT
	} op_t;

	// Loop conditions.
	typedef enum logic [2:0] {
		COND_NONE,
		COND_MONTH_GT12,
		COND_DAY_GT_LEN,
		COND_OUT_BUSY
	} cond_t;

	// One microcode word: while the condition holds the operation runs and
	// control jumps to the target; otherwise control falls through.
	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            last;
	} ucode_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic exec;
		op_t  op;
	} ctrl_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic month_gt12;
		logic day_gt_len;
		logic out_busy;
	} status_t;

	// Program steps.
	localparam logic [PC_W-1:0] PC_NORM    = 3'd0;
	localparam logic [PC_W-1:0] PC_MOD_MUL = 3'd1;
	localparam logic [PC_W-1:0] PC_MOD_SUB = 3'd2;
	localparam logic [PC_W-1:0] PC_DAY     = 3'd3;
	localparam logic [PC_W-1:0] PC_WAIT    = 3'd4;
	localparam logic [PC_W-1:0] PC_EMIT    = 3'd5;

	// Microcode program.
	function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_NOP, cond: COND_NONE, target: PC_NORM, last: 1'b1};
		unique case (pc)
			PC_NORM:    w = '{op: OP_NORM,    cond: COND_MONTH_GT12, target: PC_NORM,
				last: 1'b0};
			PC_MOD_MUL: w = '{op: OP_MOD_MUL, cond: COND_NONE,       target: PC_MOD_MUL,
				last: 1'b0};
			PC_MOD_SUB: w = '{op: OP_MOD_SUB, cond: COND_NONE,       target: PC_MOD_SUB,
				last: 1'b0};
			PC_DAY:     w = '{op: OP_DAY,     cond: COND_DAY_GT_LEN, target: PC_DAY,
				last: 1'b0};
			PC_WAIT:    w = '{op: OP_NOP,     cond: COND_OUT_BUSY,   target: PC_WAIT,
				last: 1'b0};
			PC_EMIT:    w = '{op: OP_EMIT,    cond: COND_NONE,       target: PC_EMIT,
				last: 1'b1};
			default:    w = '{op: OP_NOP,     cond: COND_NONE,       target: PC_NORM,
				last: 1'b1};
		endcase
		return w;
	endfunction

	// Length of a month, month in 1..12.
	function automatic logic [DAY_IO_W-1:0] month_len(input logic [MONTH_IO_W-1:0] m,
		input logic leap);
		logic [DAY_IO_W-1:0] len;
		case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== sv/dpa_if.sv =====
// ----------------------------------------------------------------------------
// dpa_if
// Request and result channels of the date period adder, valid/ready.
// ----------------------------------------------------------------------------
interface dpa_req_if import dpa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [YEAR_IO_W-1:0]   start_year;
	logic [MONTH_IO_W-1:0]  start_month;
	logic [DAY_IO_W-1:0]    start_day;
	logic [ADD_YEARS_W-1:0] add_years;
	logic [ADD_MONTH_W-1:0] add_months;
	logic [ADD_DAYS_W-1:0]  add_days;

	modport source(output valid, start_year, start_month, start_day, add_years,
		add_months, add_days, input ready);
	modport sink(input valid, start_year, start_month, start_day, add_years,
		add_months, add_days, output ready);
endinterface

interface dpa_rsp_if import dpa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [YEAR_IO_W-1:0]  result_year;
	logic [MONTH_IO_W-1:0] result_month;
	logic [DAY_IO_W-1:0]   result_day;
	logic                  year_overflow;

	modport source(output valid, result_year, result_month, result_day, year_overflow,
		input ready);
	modport sink(input valid, result_year, result_month, result_day, year_overflow,
		output ready);
endinterface

// ===== sv/date_period_adder_unit.sv =====
// ----------------------------------------------------------------------------
// date_period_adder_unit
// Steps: the month carry loop, a pass per twelve carried out of the month sum;
// the two year modulo steps; the day loop, a pass per month stepped off the day
// sum; a wait while an earlier result holds the output register; the emit.
// Throughput: one request at a time; the next is taken once the result
// register is loaded, so the one-month-per-cycle loop sets the rate.
// Reset clears the sequencer and the result valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module date_period_adder_unit import dpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dpa_req_if.sink   req,
	dpa_rsp_if.source rsp
);

	ctrl_t   ctrl;
	status_t status;
	logic    busy;
	logic    start;

	// A request is taken whenever no earlier one is still being worked.
	assign req.ready = !busy;
	assign start     = req.valid && !busy;

	dpa_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	dpa_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.start_year  (req.start_year),
		.start_month (req.start_month),
		.start_day   (req.start_day),
		.add_years   (req.add_years),
		.add_months  (req.add_months),
		.add_days    (req.add_days),
		.ctrl        (ctrl),
		.status      (status),
		.rsp         (rsp)
	);

endmodule

// ===== sv/dpa_sequencer.sv =====
// ----------------------------------------------------------------------------
// dpa_sequencer
// Step counter and microcode store. Evaluates the loop condition of the
// current step and issues one datapath operation per cycle while it holds.
// ----------------------------------------------------------------------------
module dpa_sequencer import dpa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output ctrl_t   ctrl,
	output logic    busy
);

	logic [PC_W-1:0] pc_q;
	logic            busy_q;
	ucode_t          word;
	logic            cond_true;

	// Fetch and condition select.
	always_comb begin
		word = ucode_word(pc_q);
		unique case (word.cond)
			COND_NONE:       cond_true = 1'b1;
			COND_MONTH_GT12: cond_true = status.month_gt12;
			COND_DAY_GT_LEN: cond_true = status.day_gt_len;
			COND_OUT_BUSY:   cond_true = status.out_busy;
			default:         cond_true = 1'b0;
		endcase
	end

	assign ctrl.exec = busy_q && cond_true;
	assign ctrl.op   = word.op;
	assign busy      = busy_q;

	// Step counter: loop on the target while the condition holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PC_NORM;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q   <= PC_NORM;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cond_true && word.cond != COND_NONE) begin
				pc_q <= word.target;
			end else if (word.last) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/dpa_datapath.sv =====
// ----------------------------------------------------------------------------
// dpa_datapath
// Year, month and day registers with the month carry, a two-step year
// modulo 25 unit by reciprocal multiplication for the century rule, the day
// reduction step and the result register.
// ----------------------------------------------------------------------------
module dpa_datapath import dpa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [YEAR_IO_W-1:0]   start_year,
	input  logic [MONTH_IO_W-1:0]  start_month,
	input  logic [DAY_IO_W-1:0]    start_day,
	input  logic [ADD_YEARS_W-1:0] add_years,
	input  logic [ADD_MONTH_W-1:0] add_months,
	input  logic [ADD_DAYS_W-1:0]  add_days,
	input  ctrl_t                  ctrl,
	output status_t                status,
	dpa_rsp_if.source              rsp
);

	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [REM_W-1:0]   rem_q;

	logic                  out_valid_q;
	logic [YEAR_IO_W-1:0]  out_year_q;
	logic [MONTH_IO_W-1:0] out_month_q;
	logic [DAY_IO_W-1:0]   out_day_q;
	logic                  out_ovf_q;

	logic [YEAR_IO_W-1:0]          y0;
	logic [MONTH_IO_W-1:0]         m0;
	logic [DAY_IO_W-1:0]           d0;
	logic                          leap;
	logic [DAY_IO_W-1:0]           len;
	logic [YEAR_W+RECIP_W-1:0]     recip_prod;
	logic [YEAR_W-1:0]             quot_x25;
	logic [YEAR_W-1:0]             year_rem;
	logic                          year_ovf;

	// Zero fields read as the first year, month or day.
	always_comb begin
		y0 = (start_year == '0) ? YEAR_IO_W'(1) : start_year;
		m0 = (start_month == '0) ? MONTH_IO_W'(1) : start_month;
		d0 = (start_day == '0) ? DAY_IO_W'(1) : start_day;
	end

	// Leap year: divisible by 4, and not by 100 unless by 400 (16 and 25).
	always_comb begin
		leap = (year_q[1:0] == 2'b00) && ((rem_q != '0) || (year_q[3:0] == 4'b0000));
		len  = month_len(month_q[MONTH_IO_W-1:0], leap);
	end

	// Year modulo 25: quotient by reciprocal product, then the remainder.
	always_comb begin
		recip_prod = (YEAR_W+RECIP_W)'(year_q) * (YEAR_W+RECIP_W)'(RECIP_CENTURY);
		quot_x25   = YEAR_W'(quot_q) * YEAR_W'(CENTURY_FACTOR);
		year_rem   = year_q - quot_x25;
	end

	assign year_ovf = year_q > YEAR_W'(YEAR_LIMIT);

	always_comb begin
		status.month_gt12 = month_q > MONTH_W'(MONTHS_PER_YEAR);
		status.day_gt_len = day_q > DAY_W'(len);
		status.out_busy   = out_valid_q && !rsp.ready;
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (start) begin
			year_q  <= YEAR_W'(y0) + YEAR_W'(add_years);
			month_q <= MONTH_W'(m0) + MONTH_W'(add_months);
			day_q   <= DAY_W'(d0) + DAY_W'(add_days[DAYS_WIDTH-1:0]);
		end else if (ctrl.exec) begin
			case (ctrl.op)
				OP_NORM: begin
					month_q <= month_q - MONTH_W'(MONTHS_PER_YEAR);
					year_q  <= year_q + 1'b1;
				end
				OP_MOD_MUL: begin
					quot_q <= recip_prod[YEAR_W+RECIP_W-1:QUOT_SHIFT];
				end
				OP_MOD_SUB: begin
					rem_q <= year_rem[REM_W-1:0];
				end
				OP_DAY: begin
					day_q <= day_q - DAY_W'(len);
					if (month_q == MONTH_W'(MONTHS_PER_YEAR)) begin
						month_q <= MONTH_W'(1);
						year_q  <= year_q + 1'b1;
						rem_q   <= (rem_q == REM_W'(CENTURY_FACTOR - 1)) ? '0 : rem_q + 1'b1;
					end else begin
						month_q <= month_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register, saturated year.
	always_ff @(posedge clk) begin
		if (ctrl.exec && ctrl.op == OP_EMIT) begin
			out_year_q  <= year_ovf ? YEAR_IO_W'(YEAR_LIMIT) : year_q[YEAR_IO_W-1:0];
			out_month_q <= month_q[MONTH_IO_W-1:0];
			out_day_q   <= day_q[DAY_IO_W-1:0];
			out_ovf_q   <= year_ovf;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.exec && ctrl.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.result_year   = out_year_q;
	assign rsp.result_month  = out_month_q;
	assign rsp.result_day    = out_day_q;
	assign rsp.year_overflow = out_ovf_q;

endmodule
